// ===== sv/ols_pkg.sv =====
// ols_pkg: shared types, constants and register codes for the one-lane signal controller.
// Used by ols_step, one_lane_signal_controller and ols_checker; depends on nothing.

package ols_pkg;

	// Width of the elapsed-seconds and passed-cars counters (4 to 16).
	localparam int COUNT_BITS = 8;
	localparam int LIMIT_BITS = 8;
	localparam int CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

	localparam int CARS_BITS  = 4;
	localparam int IN_BYTES   = 1;
	localparam int OUT_BYTES  = 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	typedef logic [COUNT_BITS-1:0] cnt_t;
	typedef logic [COUNT_BITS:0]   cnt_sum_t;
	typedef logic [CMP_BITS-1:0]   cmp_t;
	typedef logic [LIMIT_BITS-1:0] limit_t;

	localparam cnt_t CNT_MAX = '1;

	// Operating modes; code 3 behaves as free-for-all.
	localparam logic [1:0] MODE_FREE  = 2'd0;
	localparam logic [1:0] MODE_TIMED = 2'd1;
	localparam logic [1:0] MODE_QUOTA = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EAST_SECS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEST_SECS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EAST_QUOTA  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WEST_QUOTA  = 3'd4;

	localparam logic [1:0] MODE_RST   = MODE_TIMED;
	localparam limit_t     SECS_RST   = 8'd10;
	localparam limit_t     QUOTA_RST  = 8'd5;

	localparam logic DIR_EAST = 1'b0;

	typedef struct packed {
		logic [1:0] mode;
		limit_t     east_green_seconds;
		limit_t     west_green_seconds;
		limit_t     east_car_quota;
		limit_t     west_car_quota;
	} cfg_t;

	typedef struct packed {
		logic direction;
		logic drain;
		cnt_t elapsed;
		cnt_t passed;
	} state_t;

	typedef struct packed {
		logic                 passage_empty;
		logic [CARS_BITS-1:0] cars_passed;
		logic                 ambulance_waiting_west;
		logic                 ambulance_waiting_east;
	} item_t;

	typedef struct packed {
		logic preempted;
		logic count_cleared;
		logic controlled;
		logic draining;
		logic direction;
	} result_t;

endpackage

// ===== sv/one_lane_signal_controller.sv =====
// Channel   Dir  Width  Contents (lowest bit first)
// s_axis    in   8      ambulance_waiting_east, ambulance_waiting_west, cars_passed[3:0],
//                       passage_empty, unused
// m_axis    out  8      direction, draining, controlled, count_cleared, preempted, zeros
// cfg       in   3+8    cfg_we, cfg_index, cfg_data; no read-back
//
// One item per cycle sustained while the output is not stalled.
// A tick is captured in an input register, stepped through ols_step, and the result
// lands in an output register while the controller state updates in the same edge.
// A stalled output holds its result and the input register; s_axis_tready follows.
// arst_n clears the valid flags and the controller state and loads the config registers' reset values.

module one_lane_signal_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// ambulance_waiting_east, ambulance_waiting_west, cars_passed, passage_empty, pad
	input  logic [8*ols_pkg::IN_BYTES-1:0] s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// direction, draining, controlled, count_cleared, preempted, pad
	output logic [8*ols_pkg::OUT_BYTES-1:0] m_axis_tdata,
	input  logic                           cfg_we,
	input  logic [ols_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ols_pkg::CFG_DATA_W-1:0] cfg_data
);

	ols_pkg::cfg_t    cfg_q;
	ols_pkg::state_t  state_q;
	ols_pkg::state_t  state_nxt;
	ols_pkg::item_t   item_s1;
	logic             valid_s1;
	ols_pkg::result_t res_nxt;
	ols_pkg::result_t result_q;
	logic             out_valid_q;
	logic             advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode               <= ols_pkg::MODE_RST;
			cfg_q.east_green_seconds <= ols_pkg::SECS_RST;
			cfg_q.west_green_seconds <= ols_pkg::SECS_RST;
			cfg_q.east_car_quota     <= ols_pkg::QUOTA_RST;
			cfg_q.west_car_quota     <= ols_pkg::QUOTA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ols_pkg::REG_MODE:       cfg_q.mode               <= cfg_data[1:0];
				ols_pkg::REG_EAST_SECS:  cfg_q.east_green_seconds <= cfg_data;
				ols_pkg::REG_WEST_SECS:  cfg_q.west_green_seconds <= cfg_data;
				ols_pkg::REG_EAST_QUOTA: cfg_q.east_car_quota     <= cfg_data;
				ols_pkg::REG_WEST_QUOTA: cfg_q.west_car_quota     <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= ols_pkg::item_t'(s_axis_tdata[$bits(ols_pkg::item_t)-1:0]);
		end
	end

	ols_step u_step (
		.st   (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.direction <= ols_pkg::DIR_EAST;
			state_q.drain     <= 1'b0;
			state_q.elapsed   <= '0;
			state_q.passed    <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(8*ols_pkg::OUT_BYTES - $bits(ols_pkg::result_t)){1'b0}}, result_q};

endmodule

// ===== sv/ols_step.sv =====
// ols_step: combinational next-state and result logic for one tick snapshot.
// Depends on ols_pkg for the state, config, item and result types.

module ols_step (
	input  ols_pkg::state_t  st,
	input  ols_pkg::cfg_t    cfg,
	input  ols_pkg::item_t   item,
	output ols_pkg::state_t  nxt,
	output ols_pkg::result_t res
);

	always_comb begin
		logic              ctrl;
		logic              opp_amb;
		logic              phase_end;
		logic              preempt;
		logic              cleared;
		ols_pkg::limit_t   lim;
		ols_pkg::cnt_sum_t sum;
		ols_pkg::cnt_t     cnt_sat;

		nxt       = st;
		ctrl      = (cfg.mode == ols_pkg::MODE_TIMED) || (cfg.mode == ols_pkg::MODE_QUOTA);
		opp_amb   = st.direction ? item.ambulance_waiting_east : item.ambulance_waiting_west;
		phase_end = 1'b0;
		preempt   = 1'b0;
		cleared   = 1'b0;
		lim       = '0;
		sum       = '0;
		cnt_sat   = '0;

		if (ctrl) begin
			if (st.drain) begin
				// flip once the passage has cleared
				if (item.passage_empty) begin
					nxt.direction = ~st.direction;
					nxt.drain     = 1'b0;
					nxt.elapsed   = '0;
					nxt.passed    = '0;
				end
			end else if (cfg.mode == ols_pkg::MODE_TIMED) begin
				lim = st.direction ? cfg.west_green_seconds : cfg.east_green_seconds;
				if (lim == '0) begin
					phase_end = 1'b1;
				end else begin
					sum         = ols_pkg::cnt_sum_t'(st.elapsed) + ols_pkg::cnt_sum_t'(1'b1);
					cnt_sat     = sum[ols_pkg::COUNT_BITS] ? ols_pkg::CNT_MAX
						: sum[ols_pkg::COUNT_BITS-1:0];
					nxt.elapsed = cnt_sat;
					if (opp_amb) begin
						phase_end = 1'b1;
						preempt   = 1'b1;
					end else if ((ols_pkg::cmp_t'(cnt_sat) >= ols_pkg::cmp_t'(lim))
						|| (cnt_sat == ols_pkg::CNT_MAX)) begin
						phase_end = 1'b1;
					end
				end
			end else begin
				lim = st.direction ? cfg.west_car_quota : cfg.east_car_quota;
				if (lim == '0) begin
					phase_end = 1'b1;
				end else if (opp_amb) begin
					phase_end = 1'b1;
					preempt   = 1'b1;
				end else begin
					sum        = ols_pkg::cnt_sum_t'(st.passed)
						+ ols_pkg::cnt_sum_t'(item.cars_passed);
					cnt_sat    = sum[ols_pkg::COUNT_BITS] ? ols_pkg::CNT_MAX
						: sum[ols_pkg::COUNT_BITS-1:0];
					nxt.passed = cnt_sat;
					if ((ols_pkg::cmp_t'(cnt_sat) >= ols_pkg::cmp_t'(lim))
						|| (cnt_sat == ols_pkg::CNT_MAX)) begin
						phase_end = 1'b1;
					end
				end
				// every quota phase end drops the pass count
				if (phase_end) begin
					cleared    = 1'b1;
					nxt.passed = '0;
				end
			end
			if (phase_end) begin
				nxt.drain = 1'b1;
			end
		end

		res.direction     = nxt.direction;
		res.draining      = nxt.drain;
		res.controlled    = ctrl;
		res.count_cleared = cleared;
		res.preempted     = preempt;
	end

endmodule

// ===== sv/ols_checker.sv =====
// ols_checker: port-level checks for one_lane_signal_controller, bound to the top level.
// Depends on ols_pkg for port widths.

module ols_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [8*ols_pkg::OUT_BYTES-1:0] m_axis_tdata
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// pulses only appear when the block controls traffic
	a_pulse_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[3] || m_axis_tdata[4]) |-> m_axis_tdata[2])
		else $error("pulse reported while uncontrolled");

	// a preempted phase end always starts a drain
	a_preempt_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[1])
		else $error("preemption without drain");

	// a quota clear always starts a drain
	a_clear_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[1])
		else $error("count clear without drain");

endmodule

bind one_lane_signal_controller ols_checker u_ols_checker (.*);
